### hdl/proximity_alarm_classifier_macros.svh
// Assertion macros for the proximity alarm classifier.
// Included by the top level; no other dependencies.
`ifndef PROXIMITY_ALARM_CLASSIFIER_MACROS_SVH
`define PROXIMITY_ALARM_CLASSIFIER_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define PAC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define PAC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/pac_pkg.sv
// Shared types and constants of the proximity alarm classifier.
// No dependencies; used by the stream interface users and the top level.
package pac_pkg;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_SAFE_DISTANCE   = 2'd0,
		REG_DANGER_DISTANCE = 2'd1,
		REG_ECHO_TIMEOUT    = 2'd2
	} reg_index_t;

	// Zone codes
	typedef enum logic [1:0] {
		ZONE_SAFE    = 2'd0,
		ZONE_CAUTION = 2'd1,
		ZONE_DANGER  = 2'd2
	} zone_t;

	localparam int PULSE_W = 16;
	localparam int DIST_W  = 10;
	localparam int CFG_W   = 16;

	// Reset values of the registers
	localparam logic [DIST_W-1:0]  SAFE_RESET    = 10'd60;
	localparam logic [DIST_W-1:0]  DANGER_RESET  = 10'd30;
	localparam logic [PULSE_W-1:0] TIMEOUT_RESET = 16'd30000;

	// Distance limits in cm
	localparam logic [DIST_W-1:0] NO_TARGET = 10'd999;
	localparam logic [DIST_W-1:0] MIN_CM    = 10'd2;
	localparam logic [DIST_W-1:0] MAX_CM    = 10'd400;

	// floor(p * 343 / 20000) as (p * 343 * ceil(2^39 / 20000)) >> 39,
	// exact for every 16-bit pulse
	localparam int MUL_W      = 34;
	localparam int DIST_SHIFT = 39;
	localparam int PROD_W     = PULSE_W + MUL_W;
	localparam int CM_W       = 11;
	localparam logic [MUL_W-1:0] DIST_MUL = 34'd9428312313;

	// One sensing round
	typedef struct packed {
		logic [PULSE_W-1:0] pulse_front_left;
		logic [PULSE_W-1:0] pulse_front_right;
		logic [PULSE_W-1:0] pulse_back_left;
		logic [PULSE_W-1:0] pulse_back_right;
		logic               mute_press;
	} round_t;

	// One alarm result
	typedef struct packed {
		logic [DIST_W-1:0] dist_front_left;
		logic [DIST_W-1:0] dist_front_right;
		logic [DIST_W-1:0] dist_back_left;
		logic [DIST_W-1:0] dist_back_right;
		logic [DIST_W-1:0] nearest_distance;
		zone_t             zone;
		logic [3:0]        led_mask;
		logic              buzzer_on;
		logic              tone_high;
		logic              muted_flag;
	} result_t;

endpackage

### hdl/pac_stream_if.sv
// Valid/ready stream channel carrying one payload per request.
// The payload type is set per instance; no package dependency.
interface pac_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

### hdl/proximity_alarm_classifier.sv
// Ultrasonic parking alarm: distances, zone, LEDs and buzzer per round.
// Uses pac_pkg, pac_stream_if and proximity_alarm_classifier_macros.svh.
//
// Usage:
//   rounds  : sink channel, one request per sensing round (four echo pulse
//             widths in us and a debounced mute press).
//   results : source channel, one alarm request per round, in order.
//   cfg_*   : write port for safe_distance, danger_distance, echo_timeout;
//             write only while no round is in flight.
// Timing: a round accepted at one clock edge sits in the input register,
// and its result is loaded into the output register when the output
// register is empty or being taken. One round per cycle is sustained
// while results are taken; the whole evaluation (four constant
// multipliers for the pulse conversion, min tree, zone compare) fits the
// single stage between the two registers.
// Reset: thresholds return to 60 / 30 cm and a 30000 us timeout, mute is
// cleared and the caution beep phase returns to 0; both channels go empty.
// Stall: when results is not taken, the output register holds; the input
// register still takes one more round, then rounds.ready drops until the
// output drains.
`include "proximity_alarm_classifier_macros.svh"

module proximity_alarm_classifier
	import pac_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	pac_stream_if.sink           rounds,
	pac_stream_if.source         results,
	input  logic                 cfg_wen,
	input  logic [1:0]           cfg_addr,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	// Pulse to distance in cm, 999 for none or out of range
	function automatic logic [DIST_W-1:0] pulse_to_cm(
		input logic [PULSE_W-1:0] pulse,
		input logic [PULSE_W-1:0] timeout
	);
		logic [PROD_W-1:0] prod;
		logic [CM_W-1:0]   cm;
		prod = PROD_W'(pulse) * PROD_W'(DIST_MUL);
		cm   = prod[DIST_SHIFT+CM_W-1:DIST_SHIFT];
		if (pulse > timeout || cm < CM_W'(MIN_CM) || cm > CM_W'(MAX_CM))
			return NO_TARGET;
		else
			return cm[DIST_W-1:0];
	endfunction

	// Configuration registers
	logic [DIST_W-1:0]  safe_q;
	logic [DIST_W-1:0]  danger_q;
	logic [PULSE_W-1:0] timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			safe_q    <= SAFE_RESET;
			danger_q  <= DANGER_RESET;
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_wen) begin
			case (reg_index_t'(cfg_addr))
				REG_SAFE_DISTANCE:   safe_q    <= cfg_wdata[DIST_W-1:0];
				REG_DANGER_DISTANCE: danger_q  <= cfg_wdata[DIST_W-1:0];
				REG_ECHO_TIMEOUT:    timeout_q <= cfg_wdata[PULSE_W-1:0];
				default: ;
			endcase
		end
	end

	// Pipeline control
	logic    valid_s1;
	round_t  round_s1;
	logic    out_valid_q;
	result_t out_q;
	logic    advance;

	assign advance      = !out_valid_q || results.ready;
	assign rounds.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rounds.ready) begin
			valid_s1 <= rounds.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rounds.ready && rounds.valid) begin
			round_s1 <= rounds.payload;
		end
	end

	// Distances
	logic [DIST_W-1:0] d_fl, d_fr, d_bl, d_br;
	logic [DIST_W-1:0] min_front, min_back, nearest;

	assign d_fl = pulse_to_cm(round_s1.pulse_front_left, timeout_q);
	assign d_fr = pulse_to_cm(round_s1.pulse_front_right, timeout_q);
	assign d_bl = pulse_to_cm(round_s1.pulse_back_left, timeout_q);
	assign d_br = pulse_to_cm(round_s1.pulse_back_right, timeout_q);

	// Min tree, ties keep the earlier sensor
	assign min_front = (d_fr < d_fl) ? d_fr : d_fl;
	assign min_back  = (d_br < d_bl) ? d_br : d_bl;
	assign nearest   = (min_back < min_front) ? min_back : min_front;

	// Zone, LEDs, buzzer and the state update
	logic       muted_q;
	logic [1:0] beep_q;
	logic       muted_next;
	logic [1:0] beep_next;
	zone_t      zone;
	logic [3:0] leds;
	logic       buzz;
	logic       high;

	always_comb begin
		if (nearest > safe_q)
			zone = ZONE_SAFE;
		else if (nearest > danger_q)
			zone = ZONE_CAUTION;
		else
			zone = ZONE_DANGER;

		leds = {d_br < safe_q, d_bl < safe_q, d_fr < safe_q, d_fl < safe_q};

		muted_next = muted_q ^ round_s1.mute_press;
		beep_next  = beep_q;
		buzz       = 1'b0;
		high       = 1'b0;
		if (!muted_next) begin
			case (zone)
				ZONE_SAFE: beep_next = 2'd0;
				ZONE_CAUTION: begin
					beep_next = beep_q + 2'd1;
					buzz      = !beep_next[1];
				end
				ZONE_DANGER: begin
					buzz = 1'b1;
					high = 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			muted_q <= 1'b0;
			beep_q  <= 2'd0;
		end else if (advance && valid_s1) begin
			muted_q <= muted_next;
			beep_q  <= beep_next;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_q.dist_front_left  <= d_fl;
			out_q.dist_front_right <= d_fr;
			out_q.dist_back_left   <= d_bl;
			out_q.dist_back_right  <= d_br;
			out_q.nearest_distance <= nearest;
			out_q.zone             <= zone;
			out_q.led_mask         <= leds;
			out_q.buzzer_on        <= buzz;
			out_q.tone_high        <= high;
			out_q.muted_flag       <= muted_next;
		end
	end

	assign results.valid   = out_valid_q;
	assign results.payload = out_q;

	// Checks
	`PAC_ASSERT_NXT(a_s1_held, clk, arst_n, valid_s1 && !advance, valid_s1,
		"round dropped from input register while output stalled")
	`PAC_ASSERT_NXT(a_s1_moves, clk, arst_n, valid_s1 && advance, results.valid,
		"round in input register did not reach output")
	`PAC_ASSERT_NXT(a_phase_hold, clk, arst_n, !(valid_s1 && advance), $stable(beep_q),
		"beep phase changed without a round being evaluated")
	`PAC_ASSERT_IMP(a_mute_silent, clk, arst_n,
		results.valid && results.payload.muted_flag,
		!results.payload.buzzer_on && !results.payload.tone_high,
		"buzzer driven while muted")

endmodule
